// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, also while reset is held.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Checked only out of reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

// File: hdl/stq_pkg.sv
`timescale 1ns / 1ps
package stq_pkg;

    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = 5;
    // pool size is a power of two, so the modulo is a mask
    localparam int QUEUE_IDS   = 16;
    localparam int QUEUE_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CMD_W       = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [TIME_W-1:0] ALL_ONES = '1;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SETTIME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd2;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SW_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_INDEX  = 1'd1;

    typedef struct packed {
        logic accept;
        logic alloc_step;
        logic shead_step;
        logic swalk_step;
        logic exp_step;
        logic fin_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic set_ok;
        logic tick_due;
        logic alloc_done;
        logic ins_here;
        logic exp_stop;
        logic fin_done;
    } t_dp_stat;

endpackage

// File: hdl/stq_in_if.sv
`timescale 1ns / 1ps
interface stq_in_if import stq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   timer_index;
    logic [QUEUE_W-1:0]  queue_id;
    logic [BYTE_W-1:0]   message_byte;
    logic [TIME_W-1:0]   delay_ticks;
    modport source (output valid, command, timer_index, queue_id, message_byte,
                    delay_ticks, input ready);
    modport sink (input valid, command, timer_index, queue_id, message_byte,
                  delay_ticks, output ready);
endinterface

// File: hdl/stq_out_if.sv
`timescale 1ns / 1ps
interface stq_out_if import stq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic                alloc_ok;
    logic [QUEUE_W-1:0]  dest_queue;
    logic [BYTE_W-1:0]   payload;
    logic                last;
    modport source (output valid, kind, slot, alloc_ok, dest_queue, payload, last,
                    input ready);
    modport sink (input valid, kind, slot, alloc_ok, dest_queue, payload, last,
                  output ready);
endinterface

// File: hdl/stq_cfg_if.sv
`timescale 1ns / 1ps
interface stq_cfg_if import stq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/stq_ctrl.sv
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_stat         i_stat,
    output logic             o_in_ready,
    output t_ctrl_cmd        o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_SHEAD = 3'd2;
    localparam logic [2:0] S_SWALK = 3'd3;
    localparam logic [2:0] S_EXP   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.alloc_step = (r_state == S_ALLOC);
        o_cmd.shead_step = (r_state == S_SHEAD);
        o_cmd.swalk_step = (r_state == S_SWALK);
        o_cmd.exp_step   = (r_state == S_EXP);
        o_cmd.fin_step   = (r_state == S_FIN);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_ALLOC:   n_state = S_ALLOC;
                        CMD_SETTIME: n_state = i_stat.set_ok ? S_SHEAD : S_IDLE;
                        CMD_TICK:    n_state = i_stat.tick_due ? S_EXP : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC: if (i_stat.alloc_done) n_state = S_IDLE;
            S_SHEAD: n_state = i_stat.ins_here ? S_IDLE : S_SWALK;
            S_SWALK: if (i_stat.ins_here) n_state = S_IDLE;
            S_EXP:   if (i_stat.exp_stop) n_state = S_FIN;
            S_FIN:   if (i_stat.fin_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/stq_dpath.sv
`timescale 1ns / 1ps
module stq_dpath import stq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_stat              o_stat,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [SLOT_W-1:0]     i_timer_index,
    input  logic [QUEUE_W-1:0]    i_queue_id,
    input  logic [BYTE_W-1:0]     i_message_byte,
    input  logic [TIME_W-1:0]     i_delay_ticks,
    input  logic                  i_cfg_write,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_alloc_ok,
    output logic [QUEUE_W-1:0]    o_dest_queue,
    output logic [BYTE_W-1:0]     o_payload,
    output logic                  o_last
);

    logic [1:0]          r_status   [TIMER_SLOTS];
    logic [TIME_W-1:0]   r_deadline [TIMER_SLOTS];
    logic [SLOT_W-1:0]   r_link     [TIMER_SLOTS];
    logic [QUEUE_W-1:0]  r_queue    [TIMER_SLOTS];
    logic [BYTE_W-1:0]   r_byte     [TIMER_SLOTS];

    logic [SLOT_W-1:0]   r_head;
    logic [TIME_W-1:0]   r_tick;
    logic [TIME_W-1:0]   r_earliest;
    logic [SLOT_W-1:0]   r_idx;
    logic [TIME_W-1:0]   r_dl;
    logic [SLOT_W-1:0]   r_ptr;      // alloc scan, insert prev, expiry cursor
    logic                r_sw;
    logic                r_pend_v;
    logic [SLOT_W-1:0]   r_pend_slot;
    logic [QUEUE_W-1:0]  r_pend_q;
    logic [BYTE_W-1:0]   r_pend_b;
    logic                r_out_v;
    logic [KIND_W-1:0]   r_kind;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_ok;
    logic [QUEUE_W-1:0]  r_oq;
    logic [BYTE_W-1:0]   r_ob;
    logic                r_last;
    logic                r_sw_en;
    logic [SLOT_W-1:0]   r_sw_idx;

    logic                out_free;
    logic [SLOT_W-1:0]   lnk;
    logic [SLOT_W-1:0]   rd_addr;
    logic [TIME_W-1:0]   rd_dl;
    logic [TIME_W-1:0]   tick_nx;
    logic                idx_ok;
    logic                alloc_hit;
    logic                alloc_end;
    logic                alloc_emit;
    logic                exp_stop;
    logic                is_sw;
    logic                exp_adv;
    logic                ins_here;
    logic                out_load;

    assign out_free  = !r_out_v || i_out_ready;
    assign lnk       = r_link[r_ptr];
    assign rd_addr   = i_cmd.shead_step ? r_head : (i_cmd.swalk_step ? lnk : r_ptr);
    assign rd_dl     = (rd_addr == '0) ? ALL_ONES : r_deadline[rd_addr];
    assign tick_nx   = r_tick + TIME_W'(1);
    assign idx_ok    = {1'b0, i_timer_index} < (SLOT_W + 1)'(TIMER_SLOTS);
    assign alloc_hit = (r_status[r_ptr] == ST_FREE);
    assign alloc_end = (r_ptr == SLOT_W'(TIMER_SLOTS - 1));
    assign alloc_emit = i_cmd.alloc_step && (alloc_hit || alloc_end) && out_free;
    assign exp_stop  = (r_ptr == '0) || (rd_dl > r_tick);
    assign is_sw     = r_sw_en && (r_ptr == r_sw_idx);
    // an expiring message waits when the held one cannot leave yet
    assign exp_adv   = i_cmd.exp_step && !exp_stop && (is_sw || !r_pend_v || out_free);
    assign ins_here  = (r_dl <= rd_dl) || (i_cmd.swalk_step && lnk == '0);
    // output register takes a new result this cycle
    assign out_load  = alloc_emit || (exp_adv && !is_sw && r_pend_v)
                       || (i_cmd.fin_step && out_free && (r_pend_v || r_sw));

    always_comb begin
        o_stat            = '0;
        o_stat.set_ok     = idx_ok && (r_status[i_timer_index] != ST_RUN);
        o_stat.tick_due   = !(r_earliest > tick_nx);
        o_stat.alloc_done = alloc_emit;
        o_stat.ins_here   = ins_here;
        o_stat.exp_stop   = exp_stop;
        o_stat.fin_done   = !r_pend_v && !r_sw;
    end

    // status flags, set by reset: slot 0 running, all others free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                r_status[i] <= (i == 0) ? ST_RUN : ST_FREE;
            end
        end else begin
            if (i_cmd.accept && i_command == CMD_FREE && idx_ok
                && r_status[i_timer_index] != ST_RUN) begin
                r_status[i_timer_index] <= ST_FREE;
            end
            if (i_cmd.accept && i_command == CMD_SETTIME && o_stat.set_ok) begin
                r_status[i_timer_index] <= ST_RUN;
            end
            if (i_cmd.alloc_step && alloc_hit && out_free) begin
                r_status[r_ptr] <= ST_ALLOC;
            end
            if (exp_adv) begin
                r_status[r_ptr] <= ST_ALLOC;
            end
        end
    end

    // slot storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_command == CMD_INIT && idx_ok) begin
            r_queue[i_timer_index] <= i_queue_id & QUEUE_W'(QUEUE_IDS - 1);
            r_byte[i_timer_index]  <= i_message_byte;
        end
        if (i_cmd.accept && i_command == CMD_SETTIME && o_stat.set_ok) begin
            r_deadline[i_timer_index] <= i_delay_ticks + r_tick;
        end
        if (i_cmd.shead_step && ins_here) begin
            r_link[r_idx] <= r_head;
        end
        if (i_cmd.swalk_step && ins_here) begin
            r_link[r_ptr] <= r_idx;
            r_link[r_idx] <= lnk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_timer_index;
            r_dl  <= i_delay_ticks + r_tick;
            r_ptr <= (i_command == CMD_TICK) ? r_head : '0;
        end else if (i_cmd.alloc_step && !alloc_hit && !alloc_end) begin
            r_ptr <= r_ptr + SLOT_W'(1);
        end else if (i_cmd.shead_step) begin
            r_ptr <= r_head;
        end else if (i_cmd.swalk_step || exp_adv) begin
            r_ptr <= lnk;
        end
        if (exp_adv && !is_sw) begin
            r_pend_slot <= r_ptr;
            r_pend_q    <= r_queue[r_ptr];
            r_pend_b    <= r_byte[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tick     <= '0;
            r_earliest <= ALL_ONES;
            r_sw       <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_sw_en    <= 1'b0;
            r_sw_idx   <= '0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_SW_ENABLE: r_sw_en  <= i_cfg_data[0];
                    CFG_SW_INDEX:  r_sw_idx <= i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_command == CMD_TICK) begin
                r_tick <= tick_nx;
                r_sw   <= 1'b0;
            end
            if (i_cmd.shead_step && ins_here) begin
                r_head     <= r_idx;
                r_earliest <= r_dl;
            end
            if (i_cmd.exp_step && exp_stop) begin
                r_head     <= r_ptr;
                r_earliest <= rd_dl;
            end

            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (alloc_emit) begin
                r_kind  <= KIND_ALLOC;
                r_slot  <= alloc_hit ? r_ptr : '0;
                r_ok    <= alloc_hit;
                r_oq    <= '0;
                r_ob    <= '0;
                r_last  <= 1'b1;
            end
            if (exp_adv) begin
                if (is_sw) begin
                    r_sw <= 1'b1;
                end else begin
                    if (r_pend_v) begin
                        r_kind  <= KIND_EXPIRY;
                        r_slot  <= r_pend_slot;
                        r_ok    <= 1'b0;
                        r_oq    <= r_pend_q;
                        r_ob    <= r_pend_b;
                        r_last  <= 1'b0;
                    end
                    r_pend_v <= 1'b1;
                end
            end
            if (i_cmd.fin_step && out_free) begin
                if (r_pend_v) begin
                    r_kind   <= KIND_EXPIRY;
                    r_slot   <= r_pend_slot;
                    r_ok     <= 1'b0;
                    r_oq     <= r_pend_q;
                    r_ob     <= r_pend_b;
                    r_last   <= !r_sw;
                    r_pend_v <= 1'b0;
                end else if (r_sw) begin
                    r_kind  <= KIND_SWITCH;
                    r_slot  <= r_sw_idx;
                    r_ok    <= 1'b0;
                    r_oq    <= '0;
                    r_ob    <= '0;
                    r_last  <= 1'b1;
                    r_sw    <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_kind       = r_kind;
    assign o_slot       = r_slot;
    assign o_alloc_ok   = r_ok;
    assign o_dest_queue = r_oq;
    assign o_payload    = r_ob;
    assign o_last       = r_last;

endmodule

// File: hdl/sorted_timer_queue_unit.sv
`timescale 1ns / 1ps
// Sorted timer queue: 32 timer slots, one list ordered by deadline.
// Channels: i_in takes requests (alloc, free, init, settime, tick); o_out
// returns results (alloc replies, expiry messages, task switch request) with
// last set on the final result of a request; i_cfg writes switch_timer_enable
// (index 0) and switch_timer_index (index 1) and is always ready.
// One request at a time; free, init and ignored requests finish when taken.
// alloc scans the status flags one slot a cycle from slot 0 (the sentinel is
// never free) and waits on its reply while the output register is held.
// settime walks the list one link a cycle.
// tick walks the due timers one a cycle unless a held result waits on the
// output, then drains the held result and the switch request.
// Reset: all slots free but the sentinel (slot 0, deadline all ones), list
// empty, tick count zero, flags clear. No clearing pass is needed.
// A stalled receiver holds the output register; the walk then pauses with
// one further result held internally, and no request is taken meanwhile.
module sorted_timer_queue_unit import stq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out,
    stq_cfg_if.sink   i_cfg
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    assign i_cfg.ready = 1'b1;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    stq_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_command      (i_in.command),
        .i_timer_index  (i_in.timer_index),
        .i_queue_id     (i_in.queue_id),
        .i_message_byte (i_in.message_byte),
        .i_delay_ticks  (i_in.delay_ticks),
        .i_cfg_write    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_kind         (o_out.kind),
        .o_slot         (o_out.slot),
        .o_alloc_ok     (o_out.alloc_ok),
        .o_dest_queue   (o_out.dest_queue),
        .o_payload      (o_out.payload),
        .o_last         (o_out.last)
    );

endmodule

// File: hdl/stq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stq_checker import stq_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [KIND_W-1:0]  i_kind,
    input logic               i_alloc_ok,
    input logic [QUEUE_W-1:0] i_dest_queue,
    input logic [BYTE_W-1:0]  i_payload,
    input logic               i_last
);

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid)
    `ASSERT_RST(a_alloc_last, i_clk, i_rst_n, i_valid && i_kind == KIND_ALLOC |-> i_last)
    `ASSERT_RST(a_ok_alloc, i_clk, i_rst_n, i_valid && i_alloc_ok |-> i_kind == KIND_ALLOC)
    `ASSERT_ALWAYS(a_switch_form, i_clk, i_rst_n && i_valid && i_kind == KIND_SWITCH |-> i_last && i_dest_queue == '0 && i_payload == '0)

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_kind       (o_out.kind),
    .i_alloc_ok   (o_out.alloc_ok),
    .i_dest_queue (o_out.dest_queue),
    .i_payload    (o_out.payload),
    .i_last       (o_out.last)
);
